FILE: rtl/core/kodt_pkg.sv
// Shared types and constants for the key owner directory.
`timescale 1ns / 1ps

package kodt_pkg;

    // Field widths of one request and one result.
    localparam int KEY_W  = 32;
    localparam int RANK_W = 16;
    localparam int PROC_W = 8;
    localparam int SIZE_W = 32;
    localparam int NODE_W = 17;

    // Stream payload widths; the data widths are padded to whole bytes.
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 64;
    localparam int OUT_USER_W = 2;

    // Request queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    // Reset value of the node count register.
    localparam logic [NODE_W-1:0] NODE_COUNT_RESET = 17'd1;

    // Request kinds.
    typedef enum logic {
        OP_SET    = 1'b0,
        OP_LOOKUP = 1'b1
    } op_t;

    // Configuration register index.
    typedef enum logic {
        REG_NODE_COUNT = 1'b0
    } reg_idx_t;

    // One request as it travels through the block.
    typedef struct packed {
        op_t               op;
        logic [KEY_W-1:0]  key;
        logic [RANK_W-1:0] rank;
        logic [PROC_W-1:0] proc;
        logic [SIZE_W-1:0] size;
    } req_t;

    // One way of a bucket row in the table memory.
    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [RANK_W-1:0] rank;
        logic [PROC_W-1:0] proc;
        logic [SIZE_W-1:0] size;
    } way_t;

    // One result.
    typedef struct packed {
        logic              found;
        logic [NODE_W-1:0] rank;
        logic [PROC_W-1:0] proc;
        logic [SIZE_W-1:0] size;
        logic              full;
    } res_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RESOLVE
    } back_state_t;

endpackage

FILE: rtl/core/kodt_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module kodt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH > 1 ? DEPTH : 2)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/kodt_front.sv
// Front end: accepts requests, computes the bucket index and queues them.
`timescale 1ns / 1ps

module kodt_front #(
    parameter int BUCKETS = 1024,
    localparam int BKT_W = $clog2(BUCKETS > 1 ? BUCKETS : 2)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  kodt_pkg::req_t     in_req,
    output logic               q_valid,
    input  logic               q_pop,
    output kodt_pkg::req_t     q_req,
    output logic [BKT_W-1:0]   q_bucket
);

    import kodt_pkg::*;

    // Exact reciprocal for key / BUCKETS over all 32-bit keys.
    localparam int SHIFT = 32 + $clog2(BUCKETS);
    localparam logic [32:0] RECIP = 33'(((64'd1 << SHIFT) / 64'(BUCKETS)) + 64'd1);

    logic              accept;
    logic [64:0]       prod_in;

    logic              s1_valid_reg;
    req_t              s1_req_reg;
    logic [64:0]       s1_prod_reg;

    logic [31:0]       quot;
    logic [31:0]       rem;

    logic              s2_valid_reg;
    req_t              s2_req_reg;
    logic [BKT_W-1:0]  s2_bkt_reg;

    req_t              fifo_req [QDEPTH];
    logic [BKT_W-1:0]  fifo_bkt [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [QCNT_W:0]   occupancy;
    logic              push;

    // Credit check: the queue has room for everything still in flight.
    assign occupancy = (QCNT_W+1)'(count_reg) + (QCNT_W+1)'(s1_valid_reg)
                     + (QCNT_W+1)'(s2_valid_reg);
    assign in_ready  = occupancy < (QCNT_W+1)'(QDEPTH);
    assign accept    = in_valid && in_ready;

    // Stage 1: multiply the key by the reciprocal.
    assign prod_in = 65'(in_req.key) * 65'(RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg  <= in_req;
            s1_prod_reg <= prod_in;
        end
    end

    // Stage 2: remainder from the quotient gives the bucket.
    assign quot = 32'(s1_prod_reg >> SHIFT);
    assign rem  = s1_req_reg.key - 32'(quot * 32'(BUCKETS));

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            s2_req_reg <= s1_req_reg;
            s2_bkt_reg <= rem[BKT_W-1:0];
        end
    end

    // Request queue.
    assign push        = s2_valid_reg;
    assign wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
    assign count_next  = count_reg + QCNT_W'(push) - QCNT_W'(q_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_req[wr_ptr_reg] <= s2_req_reg;
            fifo_bkt[wr_ptr_reg] <= s2_bkt_reg;
        end
    end

    assign q_valid  = count_reg != '0;
    assign q_req    = fifo_req[rd_ptr_reg];
    assign q_bucket = fifo_bkt[rd_ptr_reg];

endmodule

FILE: rtl/core/kodt_back.sv
// Back end: clears the table, then reads, resolves and writes back one bucket per request.
`timescale 1ns / 1ps

module kodt_back #(
    parameter int BUCKETS = 1024,
    parameter int WAYS = 4,
    localparam int BKT_W = $clog2(BUCKETS > 1 ? BUCKETS : 2)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [kodt_pkg::NODE_W-1:0]   node_count,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  kodt_pkg::req_t                q_req,
    input  logic [BKT_W-1:0]              q_bucket,
    output logic                          out_valid,
    input  logic                          out_ready,
    output kodt_pkg::res_t                out_res
);

    import kodt_pkg::*;

    localparam int WAY_W = $clog2(WAYS > 1 ? WAYS : 2);
    localparam int ROW_W = WAYS * $bits(way_t);

    back_state_t      state_reg, state_next;
    logic [BKT_W-1:0] clr_reg, clr_next;
    req_t             cur_reg;
    logic [BKT_W-1:0] cur_bkt_reg;
    logic             out_valid_reg, out_valid_next;
    res_t             out_res_reg;

    logic             ram_we;
    logic [BKT_W-1:0] ram_waddr;
    logic [ROW_W-1:0] ram_wdata;
    logic             ram_re;
    logic [ROW_W-1:0] ram_rdata;

    way_t [WAYS-1:0]  row_rd;
    way_t [WAYS-1:0]  row_wr;
    logic             hit_any, free_any;
    logic [WAY_W-1:0] hit_idx, free_idx, target;
    way_t             hit_way;
    logic             out_free, issue, resolve_go, write_ok;
    res_t             res_now;

    // Table memory: one row per bucket, all ways side by side.
    kodt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (BUCKETS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (q_bucket),
        .rdata (ram_rdata)
    );

    assign row_rd = ram_rdata;

    // Way match and lowest free way.
    always_comb
    begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            if (row_rd[w].valid)
            begin
                if (!hit_any && row_rd[w].key == cur_reg.key)
                begin
                    hit_any = 1'b1;
                    hit_idx = WAY_W'(w);
                end
            end
            else if (!free_any)
            begin
                free_any = 1'b1;
                free_idx = WAY_W'(w);
            end
        end
    end

    assign hit_way  = row_rd[hit_idx];
    assign target   = hit_any ? hit_idx : free_idx;
    assign write_ok = (cur_reg.op == OP_SET) && (hit_any || free_any);

    // Result shows the entry as it was before this request.
    always_comb
    begin
        res_now.found = hit_any;
        res_now.rank  = hit_any ? {1'b0, hit_way.rank} : node_count;
        res_now.proc  = hit_any ? hit_way.proc : '0;
        res_now.size  = hit_any ? hit_way.size : '0;
        res_now.full  = (cur_reg.op == OP_SET) && !hit_any && !free_any;
    end

    // Updated bucket row.
    always_comb
    begin
        row_wr               = row_rd;
        row_wr[target].valid = 1'b1;
        row_wr[target].key   = cur_reg.key;
        row_wr[target].rank  = cur_reg.rank;
        row_wr[target].proc  = cur_reg.proc;
        row_wr[target].size  = cur_reg.size;
    end

    assign out_free   = !out_valid_reg || out_ready;
    assign issue      = (state_reg == ST_IDLE) && q_valid;
    assign resolve_go = (state_reg == ST_RESOLVE) && out_free;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == BKT_W'(BUCKETS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Memory and queue controls.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = cur_bkt_reg;
        ram_wdata = row_wr;
        ram_re    = 1'b0;
        q_pop     = 1'b0;
        clr_next  = clr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                ram_re = q_valid;
                q_pop  = q_valid;
            end
            ST_RESOLVE:
            begin
                ram_we = out_free && write_ok;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Output register: loaded on resolve, cleared when taken.
    always_comb
    begin
        if (resolve_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            cur_reg     <= q_req;
            cur_bkt_reg <= q_bucket;
        end
        if (resolve_go)
        begin
            out_res_reg <= res_now;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

FILE: rtl/core/key_owner_directory_table.sv
// Top level of the key owner directory: stream ports, register port and the two halves.
//
//  Channel  Direction  Handshake          Payload
//  s_*      in         s_tvalid/s_tready  tuser: opcode; tdata: key, owner_rank, proc_id, data_size
//  m_*      out        m_tvalid/m_tready  tuser: found, bucket_full; tdata: rank, proc, size
//  p*       in/out     psel/penable       node_count at byte address 0
//
// A request passes the two front stages before it reaches the four-entry queue;
// the front stops accepting while its two stages and the queue hold four requests.
// The back handles each request as a bucket row read, then compare and write
// back; a stalled output holds the back in its resolve step. After reset the
// back clears the table, one bucket row per cycle, before it takes requests.
`timescale 1ns / 1ps

module key_owner_directory_table #(
    parameter int BUCKETS = 1024,
    parameter int WAYS = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // bits: key[31:0], owner_rank[47:32], proc_id[55:48], data_size[87:56]
    input  logic [kodt_pkg::IN_DATA_W-1:0]      s_tdata,
    // bits: opcode[0]
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // bits: rank_out[16:0], proc_out[24:17], size_out[56:25], zero pad above
    output logic [kodt_pkg::OUT_DATA_W-1:0]     m_tdata,
    // bits: found[0], bucket_full[1]
    output logic [kodt_pkg::OUT_USER_W-1:0]     m_tuser,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    import kodt_pkg::*;

    localparam int BKT_W = $clog2(BUCKETS > 1 ? BUCKETS : 2);

    logic [NODE_W-1:0] node_count_reg, node_count_next;
    logic              cfg_write;
    reg_idx_t          cfg_idx;

    req_t              in_req;
    logic              q_valid, q_pop;
    req_t              q_req;
    logic [BKT_W-1:0]  q_bucket;
    res_t              res;

    // Register port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[2]);

    always_comb
    begin
        node_count_next = node_count_reg;
        prdata          = '0;
        unique case (cfg_idx)
            REG_NODE_COUNT:
            begin
                prdata = 32'(node_count_reg);
                if (cfg_write)
                begin
                    node_count_next = pwdata[NODE_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RESET;
        end
        else
        begin
            node_count_reg <= node_count_next;
        end
    end

    // Unpack the request.
    assign in_req.op   = op_t'(s_tuser);
    assign in_req.key  = s_tdata[31:0];
    assign in_req.rank = s_tdata[47:32];
    assign in_req.proc = s_tdata[55:48];
    assign in_req.size = s_tdata[87:56];

    kodt_front #(
        .BUCKETS (BUCKETS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_req   (in_req),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_req    (q_req),
        .q_bucket (q_bucket)
    );

    kodt_back #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .node_count (node_count_reg),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_req      (q_req),
        .q_bucket   (q_bucket),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (res)
    );

    // Pack the result.
    assign m_tdata = {7'b0, res.size, res.proc, res.rank};
    assign m_tuser = {res.full, res.found};

endmodule

FILE: rtl/core/kodt_checker.sv
// Port-level checks for the key owner directory, bound to the top level.
`timescale 1ns / 1ps

module kodt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [1:0]  m_tuser
);

    // A result that waits stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A result that waits does not change.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A refused set never reports a present key.
    a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("full bucket flagged on a key that was found");

    // An absent key reports zero process id and size, and no pad bits are set.
    a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata[63:17] == 47'd0)
        else $error("absent key reported nonzero fields");

endmodule

bind key_owner_directory_table kodt_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: tb/testbench.sv
// Self-checking testbench for the key owner directory table.
`timescale 1ns / 1ps

module testbench;

    import kodt_pkg::*;

    localparam int BUCKET_COUNT = 1024;
    localparam int WAY_COUNT = 4;
    localparam int ENTRY_COUNT = BUCKET_COUNT * WAY_COUNT;
    localparam int NUM_DIRECTED = 21;
    localparam int NUM_PHASES = 6;
    localparam int ITEMS_PER_PHASE = 242;
    localparam int HOT_BUCKETS = 8;
    localparam int HOT_TAGS = 6;
    localparam int LONG_HOLD = 120;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT = 500000;

    // A lookup of an absent key, or a set that adds one, right after reset.
    localparam res_t RESET_MISS = '{1'b0, 17'd1, 8'd0, 32'd0, 1'b0};
    // A set into a full bucket right after reset.
    localparam res_t FULL_MISS = '{1'b0, 17'd1, 8'd0, 32'd0, 1'b1};
    localparam res_t FROM_DIRECTORY = '0;

    // One row of the directed table; rows without a typed result use the directory model.
    typedef struct packed {
        op_t               op;
        logic [KEY_W-1:0]  key;
        logic [RANK_W-1:0] rank;
        logic [PROC_W-1:0] proc;
        logic [SIZE_W-1:0] size;
        logic              typed;
        res_t              want;
    } vector_t;

    vector_t directed_vectors [NUM_DIRECTED] = '{
        '{OP_LOOKUP, 32'h0000_0000, 16'h0000, 8'h00, 32'h0000_0000, 1'b1, RESET_MISS},
        '{OP_SET,    32'h0000_0000, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, RESET_MISS},
        '{OP_LOOKUP, 32'h0000_0000, 16'h0000, 8'h00, 32'h0000_0000, 1'b1,
          '{1'b1, 17'h0FFFF, 8'hFF, 32'hFFFF_FFFF, 1'b0}},
        '{OP_SET,    32'h0000_0000, 16'h0000, 8'h00, 32'h0000_0000, 1'b1,
          '{1'b1, 17'h0FFFF, 8'hFF, 32'hFFFF_FFFF, 1'b0}},
        '{OP_SET,    32'h0000_0400, 16'h0001, 8'h01, 32'h0000_0001, 1'b1, RESET_MISS},
        '{OP_SET,    32'h0000_0800, 16'h1234, 8'h56, 32'h789A_BCDE, 1'b0, FROM_DIRECTORY},
        '{OP_SET,    32'h0000_0C00, 16'h8000, 8'h80, 32'h8000_0000, 1'b0, FROM_DIRECTORY},
        '{OP_SET,    32'h0000_1000, 16'h4321, 8'h21, 32'h0000_1000, 1'b1, FULL_MISS},
        '{OP_LOOKUP, 32'h0000_1000, 16'h0000, 8'h00, 32'h0000_0000, 1'b1, RESET_MISS},
        '{OP_SET,    32'h0000_0000, 16'h0005, 8'h06, 32'h0000_0007, 1'b1,
          '{1'b1, 17'h00000, 8'h00, 32'h0000_0000, 1'b0}},
        '{OP_LOOKUP, 32'h0000_0C00, 16'h0000, 8'h00, 32'h0000_0000, 1'b0, FROM_DIRECTORY},
        '{OP_LOOKUP, 32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 1'b1, RESET_MISS},
        '{OP_SET,    32'hFFFF_FFFF, 16'hAAAA, 8'h55, 32'hA5A5_A5A5, 1'b1, RESET_MISS},
        '{OP_LOOKUP, 32'hFFFF_FFFF, 16'h0000, 8'h00, 32'h0000_0000, 1'b1,
          '{1'b1, 17'h0AAAA, 8'h55, 32'hA5A5_A5A5, 1'b0}},
        '{OP_SET,    32'h0000_03FF, 16'h5555, 8'hAA, 32'h5A5A_5A5A, 1'b0, FROM_DIRECTORY},
        '{OP_LOOKUP, 32'h0000_03FF, 16'h0000, 8'h00, 32'h0000_0000, 1'b0, FROM_DIRECTORY},
        '{OP_LOOKUP, 32'h0000_0800, 16'h0000, 8'h00, 32'h0000_0000, 1'b0, FROM_DIRECTORY},
        '{OP_SET,    32'h8000_0000, 16'h7FFF, 8'h7F, 32'h7FFF_FFFF, 1'b1, FULL_MISS},
        '{OP_SET,    32'h0000_0001, 16'h5555, 8'hAA, 32'h5A5A_5A5A, 1'b0, FROM_DIRECTORY},
        '{OP_LOOKUP, 32'h0000_0001, 16'h0000, 8'h00, 32'h0000_0000, 1'b0, FROM_DIRECTORY},
        '{OP_LOOKUP, 32'h0001_0001, 16'h0000, 8'h00, 32'h0000_0000, 1'b0, FROM_DIRECTORY}
    };

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // bits: key[31:0], owner_rank[47:32], proc_id[55:48], data_size[87:56]
    logic [IN_DATA_W-1:0]  s_tdata;
    // bits: opcode[0]
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // bits: rank_out[16:0], proc_out[24:17], size_out[56:25], zero pad above
    logic [OUT_DATA_W-1:0] m_tdata;
    // bits: found[0], bucket_full[1]
    logic [OUT_USER_W-1:0] m_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [2:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    // Directory model state.
    logic              dir_valid [ENTRY_COUNT];
    logic [KEY_W-1:0]  dir_key   [ENTRY_COUNT];
    logic [RANK_W-1:0] dir_rank  [ENTRY_COUNT];
    logic [PROC_W-1:0] dir_proc  [ENTRY_COUNT];
    logic [SIZE_W-1:0] dir_size  [ENTRY_COUNT];
    logic [NODE_W-1:0] node_count_shadow;

    res_t              pending_results [$];
    logic [KEY_W-1:0]  issued_keys [$];
    logic [21:0]       hot_tags [HOT_TAGS];
    int                hot_base;
    int                mismatch_count;
    int                cycle_count;
    bit                hold_request;

    key_owner_directory_table #(
        .BUCKETS (BUCKET_COUNT),
        .WAYS    (WAY_COUNT)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Run guard: a hung block ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Resolve one request against the directory model and return its result.
    function automatic res_t resolve_request(req_t req);
        int   base;
        int   hit;
        int   free_slot;
        int   target;
        res_t res;
        base = int'(req.key % BUCKET_COUNT) * WAY_COUNT;
        hit = -1;
        free_slot = -1;
        for (int w = 0; w < WAY_COUNT; w++)
        begin
            if (dir_valid[base + w])
            begin
                if (hit < 0 && dir_key[base + w] == req.key)
                    hit = w;
            end
            else if (free_slot < 0)
            begin
                free_slot = w;
            end
        end
        res.found = (hit >= 0);
        res.rank = (hit >= 0) ? {1'b0, dir_rank[base + hit]} : node_count_shadow;
        res.proc = (hit >= 0) ? dir_proc[base + hit] : '0;
        res.size = (hit >= 0) ? dir_size[base + hit] : '0;
        res.full = 1'b0;
        if (req.op == OP_SET)
        begin
            target = (hit >= 0) ? hit : free_slot;
            if (target < 0)
            begin
                res.full = 1'b1;
            end
            else
            begin
                dir_valid[base + target] = 1'b1;
                dir_key[base + target] = req.key;
                dir_rank[base + target] = req.rank;
                dir_proc[base + target] = req.proc;
                dir_size[base + target] = req.size;
            end
        end
        return res;
    endfunction

    // Random request: mostly keys that crowd a few hot buckets, some repeats, some wild keys.
    function automatic req_t random_request();
        req_t req;
        int   pick;
        req.op = ($urandom_range(0, 99) < 50) ? OP_SET : OP_LOOKUP;
        pick = $urandom_range(0, 99);
        if (pick < 65)
        begin
            req.key = {hot_tags[$urandom_range(0, HOT_TAGS - 1)],
                       10'((hot_base + $urandom_range(0, HOT_BUCKETS - 1)) % BUCKET_COUNT)};
        end
        else if (pick < 85 && issued_keys.size() != 0)
        begin
            req.key = issued_keys[$urandom_range(0, issued_keys.size() - 1)];
        end
        else
        begin
            req.key = $urandom;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            req.rank = $urandom_range(0, 1) ? '1 : '0;
            req.proc = $urandom_range(0, 1) ? '1 : '0;
            req.size = $urandom_range(0, 1) ? '1 : '0;
        end
        else
        begin
            req.rank = 16'($urandom_range(0, 16'hFFFF));
            req.proc = 8'($urandom_range(0, 8'hFF));
            req.size = $urandom;
        end
        return req;
    endfunction

    // Offer one request until accepted, then resolve it in the model.
    task automatic offer_request(input req_t req, output res_t predicted);
        s_tvalid <= 1'b1;
        s_tuser <= req.op;
        s_tdata <= {req.size, req.proc, req.rank, req.key};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = resolve_request(req);
        issued_keys.push_back(req.key);
        if (issued_keys.size() > 256)
            void'(issued_keys.pop_front());
    endtask

    task automatic wait_for_drain();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Write the node count register, then read it back.
    task automatic write_node_count(input logic [NODE_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 3'(4 * int'(REG_NODE_COUNT));
        pwdata <= {{(32 - NODE_W){1'b0}}, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        node_count_shadow = value;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== {{(32 - NODE_W){1'b0}}, node_count_shadow})
        begin
            $display("%0t: node_count readback expected %h actual %h",
                     $time, node_count_shadow, prdata);
            mismatch_count++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Result checker: every accepted result against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        res_t got;
        res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.found = m_tuser[0];
            got.full = m_tuser[1];
            got.rank = m_tdata[16:0];
            got.proc = m_tdata[24:17];
            got.size = m_tdata[56:25];
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result expected none actual %h", $time, got);
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("found", 64'(want.found), 64'(got.found));
                compare_field("rank_out", 64'(want.rank), 64'(got.rank));
                compare_field("proc_out", 64'(want.proc), 64'(got.proc));
                compare_field("size_out", 64'(want.size), 64'(got.size));
                compare_field("bucket_full", 64'(want.full), 64'(got.full));
            end
        end
    end

    // Output back-pressure: epochs of varying stall rate, plus long holds on request.
    initial
    begin : sink_pacing
        int epoch_left;
        int stall_pct;
        int hold_left;
        m_tready = 1'b0;
        epoch_left = 0;
        stall_pct = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (epoch_left == 0)
                begin
                    epoch_left = $urandom_range(10, 150);
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 30;
                        2: stall_pct = 60;
                        default: stall_pct = 90;
                    endcase
                end
                epoch_left--;
                m_tready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Stimulus: directed table, then random phases under several node counts.
    initial
    begin : stimulus
        req_t              req;
        res_t              predicted;
        logic [NODE_W-1:0] setting;
        int                burst_left;
        int                gap;

        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        hold_request = 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        node_count_shadow = NODE_COUNT_RESET;
        for (int e = 0; e < ENTRY_COUNT; e++)
            dir_valid[e] = 1'b0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows go back to back so that requests on one bucket follow each other.
        for (int i = 0; i < NUM_DIRECTED; i++)
        begin
            req.op = directed_vectors[i].op;
            req.key = directed_vectors[i].key;
            req.rank = directed_vectors[i].rank;
            req.proc = directed_vectors[i].proc;
            req.size = directed_vectors[i].size;
            offer_request(req, predicted);
            pending_results.push_back(directed_vectors[i].typed ?
                                      directed_vectors[i].want : predicted);
        end
        s_tvalid <= 1'b0;
        wait_for_drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0: setting = '0;
                1: setting = 17'd65536;
                2: setting = '1;
                3: setting = 17'd1;
                default: setting = 17'($urandom_range(0, 17'h1FFFF));
            endcase
            write_node_count(setting);

            // Stall the output for a long stretch while requests keep coming.
            if (p == 1 || p == 4)
                hold_request = 1'b1;

            hot_base = $urandom_range(0, BUCKET_COUNT - 1);
            for (int t = 0; t < HOT_TAGS; t++)
                hot_tags[t] = (t == 0) ? '0 : (t == 1) ? '1 : 22'($urandom);

            burst_left = 0;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    if (gap > 0)
                    begin
                        s_tvalid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                end
                burst_left--;
                req = random_request();
                offer_request(req, predicted);
                pending_results.push_back(predicted);
            end
            s_tvalid <= 1'b0;
            wait_for_drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
